// ----- sv/lctr_pkg.sv -----
// Shared types, constants and response-text helpers for the line command
// telemetry responder. No dependencies.
package lctr_pkg;

	localparam int LINE_BUFFER_SIZE = 32;
	localparam int LINE_CAP         = LINE_BUFFER_SIZE - 1;
	localparam int FILL_W           = $clog2(LINE_BUFFER_SIZE);

	localparam int VAL_W   = 14;
	localparam int SOC_W   = 7;
	localparam int BCD_W   = 16;
	localparam int CFG_W   = 14;
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W   = 4;

	localparam logic [VAL_W-1:0] VAL4_MAX = VAL_W'(9999);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_V   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_V = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_I   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_I = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_SOC       = CFG_IDX_W'(4);

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_COLON = ":";

	typedef enum logic [2:0] {
		KW_UPAN = 3'd0,
		KW_UBAT = 3'd1,
		KW_CPAN = 3'd2,
		KW_CBAT = 3'd3,
		KW_SOC  = 3'd4
	} kw_t;

	localparam int NUM_KW = 5;

	typedef struct packed {
		kw_t kw;
	} cmd_t;

	function automatic logic [7:0] kw_name(input kw_t kw, input logic [1:0] pos);
		logic [31:0] name;
		begin
			case (kw)
				KW_UPAN: name = "upan";
				KW_UBAT: name = "ubat";
				KW_CPAN: name = "cpan";
				KW_CBAT: name = "cbat";
				default: name = "soc:";
			endcase
			kw_name = name[8*(3-pos) +: 8];
		end
	endfunction

	function automatic logic [7:0] digit(input logic [3:0] d);
		digit = {4'h3, d};
	endfunction

	// Soc answers with two digits skip the hundreds slot.
	function automatic logic [IDX_W-1:0] eff_idx(input kw_t kw, input logic [BCD_W-1:0] bcd,
			input logic [IDX_W-1:0] idx);
		if (kw == KW_SOC && bcd[11:8] == 4'd0 && idx >= IDX_W'(4)) begin
			eff_idx = idx + 1'b1;
		end else begin
			eff_idx = idx;
		end
	endfunction

	function automatic logic [7:0] resp_char(input kw_t kw, input logic [BCD_W-1:0] bcd,
			input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] e;
		begin
			e = eff_idx(kw, bcd, idx);
			if (kw == KW_SOC) begin
				case (e)
					4'd0, 4'd1, 4'd2, 4'd3: resp_char = kw_name(kw, e[1:0]);
					4'd4: resp_char = digit(bcd[11:8]);
					4'd5: resp_char = digit(bcd[7:4]);
					4'd6: resp_char = digit(bcd[3:0]);
					4'd7: resp_char = CH_CR;
					default: resp_char = CH_LF;
				endcase
			end else begin
				case (e)
					4'd0, 4'd1, 4'd2, 4'd3: resp_char = kw_name(kw, e[1:0]);
					4'd4: resp_char = CH_COLON;
					4'd5: resp_char = digit(bcd[15:12]);
					4'd6: resp_char = digit(bcd[11:8]);
					4'd7: resp_char = digit(bcd[7:4]);
					4'd8: resp_char = digit(bcd[3:0]);
					4'd9: resp_char = CH_CR;
					default: resp_char = CH_LF;
				endcase
			end
		end
	endfunction

	function automatic logic resp_last(input kw_t kw, input logic [BCD_W-1:0] bcd,
			input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] e;
		begin
			e = eff_idx(kw, bcd, idx);
			resp_last = (kw == KW_SOC) ? (e == IDX_W'(8)) : (e == IDX_W'(10));
		end
	endfunction

endpackage

// ----- sv/lctr_front.sv -----
// Front end: takes received beats, tracks line fill and keyword hits as the
// line streams in, and queues a command at line end. Depends on lctr_pkg.
module lctr_front import lctr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_char,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [FILL_W-1:0] fill_q;
	logic [7:0]        h1_q, h2_q, h3_q;
	logic              zero_q;
	logic [NUM_KW-1:0] found_q;
	logic [NUM_KW-1:0] hit;
	logic              accept, room, eol;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign room     = (fill_q != FILL_W'(LINE_CAP));
	assign eol      = (rx_char inside {CH_CR, CH_LF});

	always_comb begin
		hit = '0;
		hit[KW_UPAN] = ({h3_q, h2_q, h1_q, rx_char} == "uPan");
		hit[KW_UBAT] = ({h3_q, h2_q, h1_q, rx_char} == "ubat");
		hit[KW_CPAN] = ({h3_q, h2_q, h1_q, rx_char} == "cpan");
		hit[KW_CBAT] = ({h3_q, h2_q, h1_q, rx_char} == "cbat");
		hit[KW_SOC]  = ({h2_q, h1_q, rx_char} == "soc");
	end

	always_comb begin
		push_cmd.kw = KW_SOC;
		if (found_q[KW_UPAN]) begin
			push_cmd.kw = KW_UPAN;
		end else if (found_q[KW_UBAT]) begin
			push_cmd.kw = KW_UBAT;
		end else if (found_q[KW_CPAN]) begin
			push_cmd.kw = KW_CPAN;
		end else if (found_q[KW_CBAT]) begin
			push_cmd.kw = KW_CBAT;
		end
	end

	assign push = accept && room && eol && (fill_q != '0) && (|found_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			h1_q    <= '0;
			h2_q    <= '0;
			h3_q    <= '0;
			zero_q  <= 1'b0;
			found_q <= '0;
		end else if (accept) begin
			if (room && !eol) begin
				fill_q <= fill_q + 1'b1;
				if (!zero_q) begin
					if (rx_char == CH_NUL) begin
						zero_q <= 1'b1;
					end else begin
						found_q <= found_q | hit;
						h1_q    <= rx_char;
						h2_q    <= h1_q;
						h3_q    <= h2_q;
					end
				end
			end else begin
				// line end or overflow: start a fresh line
				fill_q  <= '0;
				h1_q    <= '0;
				h2_q    <= '0;
				h3_q    <= '0;
				zero_q  <= 1'b0;
				found_q <= '0;
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("command pushed into full queue");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_CAP))
		else $error("fill count past capacity");
	a_found_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (found_q == '0))
		else $error("keyword hit on empty line");

endmodule

// ----- sv/lctr_queue.sv -----
// Short command queue between front and back end. Depends on lctr_pkg.
module lctr_queue import lctr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic avail
);

	cmd_t                ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_q, rd_q;
	logic [Q_CNT_W-1:0]  cnt_q;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign avail   = (cnt_q != '0);
	assign pop_cmd = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> avail)
		else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count past depth");

endmodule

// ----- sv/lctr_back.sv -----
// Back end: holds the telemetry registers, converts the selected value to
// BCD one bit per cycle and sends the response text. Depends on lctr_pkg.
module lctr_back import lctr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 avail,
	input  cmd_t                 pop_cmd,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           tx_char,
	output logic                 last_char
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t             state_q;
	kw_t                kw_q;
	logic [VAL_W-1:0]   pv_q, bv_q, pi_q, bi_q;
	logic [SOC_W-1:0]   soc_q;
	logic [VAL_W-1:0]   bin_q, sel_val;
	logic [BCD_W-1:0]   bcd_q, bcd_adj;
	logic [IDX_W-1:0]   cnt_q, idx_q;
	logic               ov_q, load, is_last;

	assign out_valid = ov_q;
	assign pop       = (state_q == ST_IDLE) && avail;
	assign load      = (state_q == ST_SEND) && (!ov_q || !out_stall);
	assign is_last   = resp_last(kw_q, bcd_q, idx_q);

	always_comb begin
		case (pop_cmd.kw)
			KW_UPAN: sel_val = (pv_q > VAL4_MAX) ? VAL4_MAX : pv_q;
			KW_UBAT: sel_val = (bv_q > VAL4_MAX) ? VAL4_MAX : bv_q;
			KW_CPAN: sel_val = (pi_q > VAL4_MAX) ? VAL4_MAX : pi_q;
			KW_CBAT: sel_val = (bi_q > VAL4_MAX) ? VAL4_MAX : bi_q;
			default: sel_val = VAL_W'(soc_q);
		endcase
	end

	always_comb begin
		for (int i = 0; i < BCD_W / 4; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] > 4'd4) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= VAL_W'(3200);
			bv_q  <= VAL_W'(1250);
			pi_q  <= VAL_W'(150);
			bi_q  <= VAL_W'(200);
			soc_q <= SOC_W'(85);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PANEL_V:   pv_q  <= cfg_data;
				CFG_BATTERY_V: bv_q  <= cfg_data;
				CFG_PANEL_I:   pi_q  <= cfg_data;
				CFG_BATTERY_I: bi_q  <= cfg_data;
				CFG_SOC:       soc_q <= cfg_data[SOC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kw_q  <= pop_cmd.kw;
				bin_q <= sel_val;
				bcd_q <= '0;
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VAL_W-1]};
				bin_q <= {bin_q[VAL_W-2:0], 1'b0};
			end
			default: ;
		endcase
		if (load) begin
			tx_char   <= resp_char(kw_q, bcd_q, idx_q);
			last_char <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall && !load) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (avail) begin
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(VAL_W - 1)) begin
						idx_q   <= '0;
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (load) begin
						ov_q  <= 1'b1;
						idx_q <= idx_q + 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_CONV))
		else $error("pop did not start conversion");
	a_conv_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (cnt_q < IDX_W'(VAL_W)))
		else $error("conversion overran");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_last) |=> (state_q == ST_IDLE && out_valid && last_char))
		else $error("final beat did not close response");

endmodule

// ----- sv/line_command_telemetry_responder.sv -----
// Top level of the line command telemetry responder: front end, command
// queue and back end. Depends on lctr_pkg, lctr_front, lctr_queue, lctr_back.
// Input: one beat per cycle; stalls only while the two-entry command queue is full.
// Response: the line end beat passes the queue, the pop, the BCD conversion and the
// output register; then one beat per cycle while out_stall is low, 8 to 11 beats.
// The back end pops the next command only after loading the last response beat.
// Reset (async, active low) empties line, queue and output; registers take defaults.
module line_command_telemetry_responder import lctr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_char,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           tx_char,
	output logic                 last_char,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic push, q_full, pop, avail;
	cmd_t push_cmd, pop_cmd;

	lctr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_char  (rx_char),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lctr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.avail    (avail)
	);

	lctr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.avail     (avail),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_char   (tx_char),
		.last_char (last_char)
	);

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for line_command_telemetry_responder: random lines of
// command text go in, each response beat is checked against an in-bench model.
// Depends on lctr_pkg and the responder RTL.
module tb;
	import lctr_pkg::*;

	localparam int TAIL_CYCLES  = 120;
	localparam int LIMIT_CYCLES = 300000;
	localparam int PHASE_BYTES  = 36;

	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_SOC + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} reply_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           rx_char = 8'd0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           tx_char;
	logic                 last_char;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// stimulus and pacing
	logic [7:0]  rx_pending[$];
	logic        in_fire = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          phase_bytes;

	// line model
	logic [7:0]       line_buf [LINE_CAP];
	int               line_fill = 0;
	logic [VAL_W-1:0] meas [4];
	logic [SOC_W-1:0] soc_pct;
	reply_beat_t      reply_q[$];
	reply_beat_t      want;
	string            kw_text [NUM_KW] = '{"uPan", "ubat", "cpan", "cbat", "soc"};
	string            tag_text [NUM_KW] = '{"upan", "ubat", "cpan", "cbat", "soc"};

	int fail_count = 0;
	int bytes_in = 0;
	int answers = 0;
	int beats_checked = 0;

	line_command_telemetry_responder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_char   (rx_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_char   (tx_char),
		.last_char (last_char),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic add_reply(input logic [7:0] c, input logic last);
		reply_beat_t b;
		b.ch = c;
		b.last = last;
		reply_q.push_back(b);
	endtask

	task automatic predict_reply(input logic [7:0] c);
		int scan_len;
		int unsigned v;
		bit hit;
		bit same;
		string w;
		kw_t k;
		if (line_fill < LINE_CAP) begin
			if (c == CH_CR || c == CH_LF) begin
				if (line_fill > 0) begin
					scan_len = 0;
					while (scan_len < line_fill && line_buf[scan_len] != CH_NUL)
						scan_len++;
					hit = 1'b0;
					k = KW_UPAN;
					for (int i = 0; i < NUM_KW && !hit; i++) begin
						k = kw_t'(i);
						w = kw_text[i];
						for (int s = 0; s + w.len() <= scan_len && !hit; s++) begin
							same = 1'b1;
							for (int j = 0; j < w.len(); j++)
								if (line_buf[s + j] != w[j])
									same = 1'b0;
							hit = same;
						end
					end
					if (hit) begin
						answers++;
						w = tag_text[k];
						for (int j = 0; j < w.len(); j++)
							add_reply(w[j], 1'b0);
						add_reply(CH_COLON, 1'b0);
						if (k == KW_SOC) begin
							v = soc_pct;
							if (v >= 100)
								add_reply(CH_ZERO + 8'(v / 100 % 10), 1'b0);
							add_reply(CH_ZERO + 8'(v / 10 % 10), 1'b0);
							add_reply(CH_ZERO + 8'(v % 10), 1'b0);
						end else begin
							v = (meas[k] > VAL4_MAX) ? VAL4_MAX : meas[k];
							add_reply(CH_ZERO + 8'(v / 1000 % 10), 1'b0);
							add_reply(CH_ZERO + 8'(v / 100 % 10), 1'b0);
							add_reply(CH_ZERO + 8'(v / 10 % 10), 1'b0);
							add_reply(CH_ZERO + 8'(v % 10), 1'b0);
						end
						add_reply(CH_CR, 1'b0);
						add_reply(CH_LF, 1'b1);
					end
				end
				line_fill = 0;
			end else begin
				line_buf[line_fill] = c;
				line_fill++;
			end
		end else begin
			// store full: byte dropped, line discarded
			line_fill = 0;
		end
	endtask

	// driver: new beat only when the previous one went through
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_char <= rx_pending.pop_front();
			end else begin
				in_valid <= 1'b0;
				rx_char <= 8'($urandom);
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: model on accepted input beats, compare accepted output beats
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			predict_reply(rx_char);
			bytes_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (reply_q.size() == 0) begin
				fail_count++;
				if (fail_count < 50)
					$display("%0t: unexpected beat, expected none, got tx_char=%h last_char=%b",
						$time, tx_char, last_char);
			end else begin
				want = reply_q.pop_front();
				beats_checked++;
				if (tx_char !== want.ch) begin
					fail_count++;
					if (fail_count < 50)
						$display("%0t: tx_char expected %h got %h", $time, want.ch, tx_char);
				end
				if (last_char !== want.last) begin
					fail_count++;
					if (fail_count < 50)
						$display("%0t: last_char expected %b got %b", $time, want.last,
							last_char);
				end
			end
		end
	end

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PANEL_V:   meas[KW_UPAN] = data;
			CFG_BATTERY_V: meas[KW_UBAT] = data;
			CFG_PANEL_I:   meas[KW_CPAN] = data;
			CFG_BATTERY_I: meas[KW_CBAT] = data;
			CFG_SOC:       soc_pct = data[SOC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] b);
		rx_pending.push_back(b);
		phase_bytes++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	task automatic queue_line();
		int kind;
		int n;
		string w;
		string pool;
		pool = "uUPpabncstoC";
		kind = $urandom_range(99);
		w = kw_text[$urandom_range(NUM_KW - 1)];
		if (kind < 55) begin
			// command, sometimes with a second keyword to exercise precedence
			repeat ($urandom_range(4)) queue_byte(8'($urandom_range(32, 126)));
			queue_text(w);
			if ($urandom_range(3) == 0)
				queue_text(kw_text[$urandom_range(NUM_KW - 1)]);
			repeat ($urandom_range(3)) queue_byte(8'($urandom_range(32, 126)));
		end else if (kind < 67) begin
			// near-miss letters, case variants
			repeat ($urandom_range(1, 12)) queue_byte(pool[$urandom_range(pool.len() - 1)]);
		end else if (kind < 77) begin
			// NUL cuts the search
			if ($urandom_range(1)) begin
				queue_byte(CH_NUL);
				queue_text(w);
			end else begin
				queue_text(w);
				queue_byte(CH_NUL);
			end
		end else if (kind < 87) begin
			repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(255)));
		end else if (kind < 92) begin
			// empty line: terminator only
		end else begin
			// around the store limit; at 31 the terminator is dropped
			n = $urandom_range(29, 31);
			repeat (n - w.len()) queue_byte(body_byte());
			queue_text(w);
		end
		queue_byte($urandom_range(1) ? CH_CR : CH_LF);
	endtask

	task automatic settle();
		while (rx_pending.size() != 0 || in_valid || reply_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		meas[KW_UPAN] = 3200;
		meas[KW_UBAT] = 1250;
		meas[KW_CPAN] = 150;
		meas[KW_CBAT] = 200;
		soc_pct = 85;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 88;
					recv_stall_pct = 0;
					set_register(CFG_PANEL_V, '0);
					set_register(CFG_BATTERY_V, '0);
					set_register(CFG_PANEL_I, '0);
					set_register(CFG_BATTERY_I, '0);
					set_register(CFG_SOC, '0);
					set_register(CFG_UNUSED_LO, CFG_W'($urandom));
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 88;
					set_register(CFG_PANEL_V, CFG_W'(9999));
					set_register(CFG_BATTERY_V, '1);
					set_register(CFG_PANEL_I, CFG_W'(10000));
					set_register(CFG_BATTERY_I, CFG_W'($urandom_range(10000, 16383)));
					set_register(CFG_SOC, CFG_W'(100));
					set_register(CFG_UNUSED_HI, CFG_W'($urandom));
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
					set_register(CFG_PANEL_V, CFG_W'($urandom_range(9999)));
					set_register(CFG_BATTERY_V, CFG_W'($urandom_range(9999)));
					set_register(CFG_PANEL_I, CFG_W'($urandom_range(9999)));
					set_register(CFG_BATTERY_I, CFG_W'($urandom_range(9999)));
					set_register(CFG_SOC, {7'($urandom), 7'h7F});
				end
			endcase
			phase_bytes = 0;
			if (phase == 0) begin
				queue_text("uPan\n");
				queue_text("ubat\r");
				queue_text("cpan\n");
				queue_text("cbat\r");
				queue_text("soc\n");
				queue_text("\r");
				phase_bytes = 0;
			end
			while (phase_bytes < PHASE_BYTES)
				queue_line();
			settle();
		end
		$display("Sent %0d bytes over four pacing phases and register settings;", bytes_in);
		$display("%0d lines answered, %0d response beats compared.", answers, beats_checked);
		if (fail_count == 0 && reply_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("Timeout with %0d beats still expected", reply_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- line_command_telemetry_responder.f -----
sv/lctr_pkg.sv
sv/lctr_front.sv
sv/lctr_queue.sv
sv/lctr_back.sv
sv/line_command_telemetry_responder.sv
tb/tb.sv
